// File: rtl/ps2m_pkg.sv
`default_nettype none
package ps2m_pkg;

  typedef enum logic [2:0] {
    OP_CTRL_WR = 3'd0,
    OP_DATA_WR = 3'd1,
    OP_STAT_RD = 3'd2,
    OP_DATA_RD = 3'd3,
    OP_MOVE    = 3'd4,
    OP_TICK    = 3'd5
  } op_e;

  // Host command bytes and device replies.
  localparam logic [7:0] CMD_SCALE1 = 8'he6;
  localparam logic [7:0] CMD_SCALE2 = 8'he7;
  localparam logic [7:0] CMD_RES    = 8'he8;
  localparam logic [7:0] CMD_GETID  = 8'hf2;
  localparam logic [7:0] CMD_RATE   = 8'hf3;
  localparam logic [7:0] CMD_ENABLE = 8'hf4;
  localparam logic [7:0] CMD_RESEND = 8'hfe;
  localparam logic [7:0] CMD_RESET  = 8'hff;
  localparam logic [7:0] RPL_BAT    = 8'haa;
  localparam logic [7:0] RPL_ACK    = 8'hfa;

  localparam logic [7:0] ST_PARITY  = 8'h04;
  localparam logic [7:0] ST_ENABLE  = 8'h08;
  localparam logic [7:0] ST_RXFULL  = 8'h20;
  localparam logic [7:0] ST_TXBUSY  = 8'h40;
  localparam logic [7:0] ST_TXEMPTY = 8'h80;

  localparam logic [1:0] REG_PKT_EN = 2'd0;
  localparam logic [1:0] REG_SWAP   = 2'd1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  write_data;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic [2:0]  button_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] status_byte;
    logic       rx_irq;
    logic       tx_irq;
    logic       bad_command;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/ps2m_stream_if.sv
`default_nettype none
interface ps2m_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ps2_mouse_device.sv
`default_nettype none
// Emulated PS/2 mouse. Input transactions carry register accesses, movement
// reports and ticks; each yields one result transaction. Reply and packet
// bytes sit in a ring memory with a registered read port; a ring entry that
// has never been written reads as zero. An item that queues bytes writes them
// to the ring one at a time through the single write port: one or two for a
// command reply, three or four for a movement packet. A tick that sends a ring
// byte goes through decode, a registered memory read and the send, in order.
// A new item is taken only when the sequencer is idle, so not before the last
// one is through, and the result register is empty or its transaction leaves
// in the same cycle.
module ps2_mouse_device
  import ps2m_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  ps2m_stream_if.sink   in_if,
  ps2m_stream_if.source out_if,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PUSH = 4'b0010,
    S_READ = 4'b0100,
    S_FIRE = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic       pkt_en_q, swap_q;
  logic [7:0] status_q, status_d, data_q, data_d, delay_q, delay_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0] rphase_q, rphase_d, dtype_q, dtype_d, prevb_q, prevb_d;
  logic [1:0] parg_q, parg_d, detect_q, detect_d;
  logic       stream_q, stream_d, wack_q, wack_d, rxi_q, rxi_d, txi_q, txi_d;
  // Queue of bytes still to be written, and how many.
  logic [7:0] pb_q [4];
  logic [7:0] pb_d [4];
  logic [2:0] pn_q, pn_d;
  logic       bad_q, bad_d;
  logic [7:0] rdat_q, rdat_d;
  logic       ovalid_q, ovalid_d;
  out_item_t  odata_q;
  // The write pointer has wrapped at least once, so every entry is written.
  logic       ring_wrap_q, ring_wrap_d;
  // The pending ring read targets an entry that was never written.
  logic       rd_zero_q, rd_zero_d;

  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] ring_rd_q;
  logic       mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd;

  in_item_t it;
  logic     take, done;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_en_q <= 1'b1;
      swap_q   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PKT_EN[0]) pkt_en_q <= pwdata[0];
      else swap_q <= pwdata[0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SWAP[0]) prdata[0] = swap_q;
    else prdata[0] = pkt_en_q;
  end

  // Ring memory with one write and one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_wa] <= mem_wd;
    if (mem_re) ring_rd_q <= ring_mem[mem_ra];
  end

  assign it = in_if.data;
  assign in_if.ready = (state_q == S_IDLE) && (!ovalid_q || out_if.ready);
  assign take = in_if.valid && in_if.ready;
  assign out_if.valid = ovalid_q;
  assign out_if.data = odata_q;

  // Main sequencer: decode, then push bytes or read the ring and send.
  always_comb begin
    logic signed [16:0] x, y;
    logic [8:0] cx, cy;
    logic [2:0] b;
    logic [7:0] head, sb, fb;
    logic       fire_ring;
    state_d = state_q;
    status_d = status_q; data_d = data_q; delay_d = delay_q;
    rd_ptr_d = rd_ptr_q; wr_ptr_d = wr_ptr_q; count_d = count_q;
    rphase_d = rphase_q; dtype_d = dtype_q; prevb_d = prevb_q;
    parg_d = parg_q; detect_d = detect_q; stream_d = stream_q;
    wack_d = wack_q; rxi_d = rxi_q; txi_d = txi_q;
    pb_d = pb_q; pn_d = pn_q; bad_d = bad_q; rdat_d = rdat_q;
    ring_wrap_d = ring_wrap_q; rd_zero_d = rd_zero_q;
    mem_we = 1'b0; mem_wa = wr_ptr_q; mem_wd = pb_q[0];
    mem_re = 1'b0; mem_ra = rd_ptr_q;
    done = 1'b0; fire_ring = 1'b0;
    x = '0; y = '0; cx = '0; cy = '0; b = '0; head = '0; sb = '0; fb = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          bad_d = 1'b0; rdat_d = '0; pn_d = '0;
          done = 1'b1;
          case (it.operation)
            OP_CTRL_WR: begin
              if (it.write_data[3]) begin
                rphase_d = 3'd1; delay_d = 8'd20; status_d = status_q | ST_ENABLE;
              end else begin
                status_d = status_q & ~ST_ENABLE;
              end
            end
            OP_DATA_WR: begin
              status_d = (status_q & 8'h3f) | ST_TXBUSY;
              txi_d = 1'b0; wack_d = 1'b1;
              if (parg_q == 2'd1 || parg_q == 2'd2) begin
                if (parg_q == 2'd2) begin
                  case (detect_q)
                    2'd1: detect_d = (it.write_data == 8'd100) ? 2'd2 :
                                     (it.write_data == 8'd200) ? 2'd3 : 2'd0;
                    2'd2: begin
                      if (it.write_data == 8'd80) dtype_d = 3'd3;
                      detect_d = 2'd0;
                    end
                    2'd3: begin
                      if (it.write_data == 8'd80) dtype_d = 3'd4;
                      detect_d = 2'd0;
                    end
                    default: if (it.write_data == 8'd200) detect_d = 2'd1;
                  endcase
                end
                pb_d[0] = RPL_ACK; pn_d = 3'd1; parg_d = 2'd0; delay_d = 8'd20;
              end else begin
                case (it.write_data)
                  CMD_RESET: begin
                    rphase_d = 3'd2; stream_d = 1'b0; delay_d = 8'd20;
                  end
                  CMD_RESEND: delay_d = 8'd150;
                  CMD_ENABLE: begin
                    pb_d[0] = RPL_ACK; pn_d = 3'd1; stream_d = 1'b1; delay_d = 8'd20;
                  end
                  CMD_RATE: begin
                    parg_d = 2'd2; pb_d[0] = RPL_ACK; pn_d = 3'd1; delay_d = 8'd20;
                  end
                  CMD_GETID: begin
                    pb_d[0] = RPL_ACK; pb_d[1] = {5'd0, dtype_q}; pn_d = 3'd2;
                    delay_d = 8'd20;
                  end
                  CMD_RES: begin
                    parg_d = 2'd1; pb_d[0] = RPL_ACK; pn_d = 3'd1; delay_d = 8'd20;
                  end
                  CMD_SCALE1, CMD_SCALE2: begin
                    pb_d[0] = RPL_ACK; pn_d = 3'd1; delay_d = 8'd20;
                  end
                  default: bad_d = 1'b1;
                endcase
              end
            end
            OP_STAT_RD: rdat_d = status_q;
            OP_DATA_RD: begin
              rdat_d = data_q;
              status_d = status_q & ~ST_RXFULL;
              rxi_d = 1'b0;
              if (count_q != '0) delay_d = 8'd20;
              data_d = '0;
            end
            OP_MOVE: begin
              if (pkt_en_q && stream_q &&
                  !(it.move_dx == 16'sd0 && it.move_dy == 16'sd0 &&
                    it.button_bits == prevb_q)) begin
                prevb_d = it.button_bits;
                x = 17'(it.move_dx);
                y = -17'(it.move_dy);
                cx = (x < -17'sd256) ? 9'h100 : (x > 17'sd255) ? 9'h0ff : x[8:0];
                cy = (y < -17'sd256) ? 9'h100 : (y > 17'sd255) ? 9'h0ff : y[8:0];
                b = it.button_bits;
                if (swap_q) b = {b[1], b[2], b[0]};
                head = {2'b00, cy[8], cx[8], 1'b1, b};
                pb_d[0] = head; pb_d[1] = cx[7:0]; pb_d[2] = cy[7:0]; pb_d[3] = '0;
                pn_d = (dtype_q == 3'd3 || dtype_q == 3'd4) ? 3'd4 : 3'd3;
                delay_d = 8'd20;
              end
            end
            OP_TICK: begin
              if (delay_q != '0) begin
                delay_d = delay_q - 8'd1;
                if (delay_q == 8'd1) begin
                  status_d = (status_q & 8'h3f) | ST_TXEMPTY;
                  if (wack_q) begin
                    txi_d = 1'b1; wack_d = 1'b0;
                  end
                  case (rphase_q)
                    3'd1: begin
                      txi_d = 1'b1; rphase_d = 3'd3; delay_d = 8'd20;
                    end
                    3'd2: begin
                      rphase_d = 3'd3; sb = RPL_ACK; delay_d = 8'd40;
                    end
                    3'd3: begin
                      delay_d = 8'd20; sb = RPL_BAT; rphase_d = 3'd4;
                    end
                    3'd4: begin
                      rphase_d = 3'd0; sb = 8'h00; delay_d = 8'd0;
                    end
                    default: fire_ring = 1'b1;
                  endcase
                  if (rphase_q >= 3'd2 && rphase_q <= 3'd4) begin
                    data_d = sb; rxi_d = 1'b1;
                    status_d = status_d | ST_RXFULL;
                    if (^sb) status_d = status_d & ~ST_PARITY;
                    else status_d = status_d | ST_PARITY;
                  end
                end
              end
            end
            default: ;
          endcase
          if (fire_ring) begin
            done = 1'b0; mem_re = 1'b1;
            if (count_q == '0) begin
              mem_ra = (rd_ptr_q == '0) ? LAST : rd_ptr_q - AW'(1);
              // Before the first wrap, the last entry (read when the pointer is zero) is unwritten.
              rd_zero_d = (rd_ptr_q == '0) && !ring_wrap_q;
            end else begin
              rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
              count_d = count_q - CW'(1);
              rd_zero_d = 1'b0;
            end
            state_d = S_READ;
          end else if (pn_d != '0) begin
            done = 1'b0; state_d = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        if (count_q != FULL) begin
          mem_we = 1'b1;
          wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
          count_d = count_q + CW'(1);
          if (wr_ptr_q == LAST) ring_wrap_d = 1'b1;
        end
        pb_d[0] = pb_q[1]; pb_d[1] = pb_q[2]; pb_d[2] = pb_q[3];
        pn_d = pn_q - 3'd1;
        if (pn_q == 3'd1) begin
          done = 1'b1; state_d = S_IDLE;
        end
      end
      S_READ: state_d = S_FIRE;
      S_FIRE: begin
        fb = rd_zero_q ? 8'h00 : ring_rd_q;
        data_d = fb; rxi_d = 1'b1;
        status_d = status_q | ST_RXFULL;
        if (^fb) status_d = status_d & ~ST_PARITY;
        else status_d = status_d | ST_PARITY;
        done = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register, written when an item completes.
  always_comb begin
    ovalid_d = ovalid_q;
    if (out_if.ready) ovalid_d = 1'b0;
    if (done) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    pb_q <= pb_d;
    rdat_q <= rdat_d;
    if (done) begin
      odata_q.read_data   <= rdat_d;
      odata_q.status_byte <= status_d;
      odata_q.rx_irq      <= rxi_d;
      odata_q.tx_irq      <= txi_d;
      odata_q.bad_command <= bad_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      status_q <= '0; data_q <= '0; delay_q <= '0;
      rd_ptr_q <= '0; wr_ptr_q <= '0; count_q <= '0;
      rphase_q <= '0; dtype_q <= '0; prevb_q <= '0;
      parg_q <= '0; detect_q <= '0; stream_q <= 1'b0;
      wack_q <= 1'b0; rxi_q <= 1'b0; txi_q <= 1'b0;
      pn_q <= '0; bad_q <= 1'b0; ovalid_q <= 1'b0;
      ring_wrap_q <= 1'b0; rd_zero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      status_q <= status_d; data_q <= data_d; delay_q <= delay_d;
      rd_ptr_q <= rd_ptr_d; wr_ptr_q <= wr_ptr_d; count_q <= count_d;
      rphase_q <= rphase_d; dtype_q <= dtype_d; prevb_q <= prevb_d;
      parg_q <= parg_d; detect_q <= detect_d; stream_q <= stream_d;
      wack_q <= wack_d; rxi_q <= rxi_d; txi_q <= txi_d;
      pn_q <= pn_d; bad_q <= bad_d; ovalid_q <= ovalid_d;
      ring_wrap_q <= ring_wrap_d; rd_zero_q <= rd_zero_d;
    end
  end

  // The fill count never exceeds the ring depth.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= FULL)
    else $error("ring count overflow");
  // The push state always has between one and four bytes queued.
  a_push_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUSH |-> pn_q != '0 && pn_q <= 3'd4)
    else $error("push with empty queue");
  // A ring read is always followed by its send.
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_FIRE)
    else $error("read not followed by send");

endmodule
`default_nettype wire
